/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro expands to one labelled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on the rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/esd_pkg.sv */
package esd_pkg;

  // Decoder mode codes. Codes above MODE_DROP behave as normal mode.
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX2   = 3'd3;
  localparam logic [2:0] MODE_DROP   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_BYTE      = 2'd0;
  localparam logic [1:0] ST_BAD_ESC   = 2'd1;
  localparam logic [1:0] ST_SHORT_HEX = 2'd2;
  localparam logic [1:0] ST_BAD_HEX   = 2'd3;

  // Characters that the decoder recognises.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // Payload of one input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Payload of one result request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       out_last;
  } out_item_t;

  // Input register contents handed to the decoder.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Decoder result handed to the output register.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } result_t;

  // Hex digit lookup: bit 4 set when the character is a hex digit, low bits its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
    end
    return v;
  endfunction

endpackage

/* hw/rtl/esd_stream_if.sv */
// Valid/ready channel carrying one request payload.
interface esd_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/esd_in_reg.sv */
// Input register: one raw byte per cycle while free, held until the decoder takes it.
module esd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  esd_stream_if.sink      in_i,
  input  logic            advance_i,
  output esd_pkg::stage_t stage_o
);

  logic             valid_q, valid_d;
  esd_pkg::in_item_t item_q;
  logic             load;

  // The register is free when empty or when its contents move on this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_i.payload;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

/* hw/rtl/esd_decode.sv */
// Escape decoder: holds the mode and the pending high nibble and turns one raw byte into
// zero or one result.
module esd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  esd_pkg::stage_t  stage_i,
  input  logic             out_free_i,
  output logic             advance_o,
  output esd_pkg::result_t result_o
);

  logic [2:0] mode_q, mode_d;
  logic [3:0] nibble_q, nibble_d;
  logic       produce;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       out_last;
  logic [7:0] c;
  logic       last;
  logic [4:0] hv;

  assign c    = stage_i.item.in_byte;
  assign last = stage_i.item.in_last;
  assign hv   = esd_pkg::hex_value(c);

  // Next mode and result for the byte in the input register.
  always_comb begin
    mode_d   = mode_q;
    nibble_d = nibble_q;
    produce  = 1'b0;
    out_byte = esd_pkg::CH_NUL;
    status   = esd_pkg::ST_BYTE;
    out_last = last;
    unique case (mode_q)
      esd_pkg::MODE_ESC: begin
        mode_d  = esd_pkg::MODE_NORMAL;
        produce = 1'b1;
        case (c)
          esd_pkg::CH_ZERO:      out_byte = esd_pkg::CH_NUL;
          esd_pkg::CH_BACKSLASH: out_byte = esd_pkg::CH_BACKSLASH;
          esd_pkg::CH_N:         out_byte = esd_pkg::CH_LF;
          esd_pkg::CH_T:         out_byte = esd_pkg::CH_TAB;
          esd_pkg::CH_R:         out_byte = esd_pkg::CH_CR;
          esd_pkg::CH_X: begin
            if (last) begin
              status   = esd_pkg::ST_SHORT_HEX;
              out_last = 1'b1;
              nibble_d = 4'd0;
            end else begin
              produce = 1'b0;
              mode_d  = esd_pkg::MODE_HEX1;
            end
          end
          default: begin
            status   = esd_pkg::ST_BAD_ESC;
            out_last = 1'b1;
            nibble_d = 4'd0;
            mode_d   = last ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_DROP;
          end
        endcase
      end
      esd_pkg::MODE_HEX1: begin
        // The length test comes before the digit test.
        if (last) begin
          produce  = 1'b1;
          status   = esd_pkg::ST_SHORT_HEX;
          out_last = 1'b1;
          nibble_d = 4'd0;
          mode_d   = esd_pkg::MODE_NORMAL;
        end else if (!hv[4]) begin
          produce  = 1'b1;
          status   = esd_pkg::ST_BAD_HEX;
          out_last = 1'b1;
          nibble_d = 4'd0;
          mode_d   = esd_pkg::MODE_DROP;
        end else begin
          nibble_d = hv[3:0];
          mode_d   = esd_pkg::MODE_HEX2;
        end
      end
      esd_pkg::MODE_HEX2: begin
        produce  = 1'b1;
        nibble_d = 4'd0;
        if (!hv[4]) begin
          status   = esd_pkg::ST_BAD_HEX;
          out_last = 1'b1;
          mode_d   = last ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_DROP;
        end else begin
          out_byte = {nibble_q, hv[3:0]};
          mode_d   = esd_pkg::MODE_NORMAL;
        end
      end
      esd_pkg::MODE_DROP: begin
        // The rest of a failed string is discarded up to its final byte.
        if (last) begin
          mode_d = esd_pkg::MODE_NORMAL;
        end
      end
      default: begin
        mode_d  = esd_pkg::MODE_NORMAL;
        produce = 1'b1;
        if (c == esd_pkg::CH_BACKSLASH) begin
          if (last) begin
            status   = esd_pkg::ST_BAD_ESC;
            out_last = 1'b1;
            nibble_d = 4'd0;
          end else begin
            produce = 1'b0;
            mode_d  = esd_pkg::MODE_ESC;
          end
        end else begin
          out_byte = c;
        end
      end
    endcase
  end

  // A byte without a result moves on even while the output register is full.
  assign advance_o = stage_i.valid && (out_free_i || !produce);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= esd_pkg::MODE_NORMAL;
      nibble_q <= 4'd0;
    end else if (advance_o) begin
      mode_q   <= mode_d;
      nibble_q <= nibble_d;
    end
  end

  assign result_o.load          = advance_o && produce;
  assign result_o.item.out_byte = out_byte;
  assign result_o.item.status   = status;
  assign result_o.item.out_last = out_last;

endmodule

/* hw/rtl/esd_out_reg.sv */
// Result register: presents one decoded request until the sink takes it.
module esd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  esd_pkg::result_t result_i,
  esd_stream_if.source     out_o,
  output logic             out_free_o
);

  logic               valid_q, valid_d;
  esd_pkg::out_item_t item_q;

  // Free when empty or when the held result is taken this cycle.
  assign out_free_o = !valid_q || out_o.ready;
  assign valid_d    = result_i.load || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.load) begin
      item_q <= result_i.item;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = item_q;

endmodule

/* hw/rtl/escape_sequence_decoder.sv */
// Backslash escape decoder. Raw string bytes enter on in_i, one per cycle, with in_last
// set on the final byte of each string; decoded bytes leave on out_o with out_last on
// the final result of the string. \0, \\, \n, \t, \r and \xHH are decoded, other bytes
// pass through. An error gives one result with a non-zero status, a zero byte and
// out_last set, and the rest of that string is dropped. An accepted byte passes the input
// register, then the result register, and a new byte can be accepted every cycle unless
// the sink stalls the result register; the decoder mode register updates as each byte
// moves on. Bytes that complete no character (a backslash, the x and first digit of a
// hex escape, dropped bytes) give no result.
module escape_sequence_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  esd_stream_if.sink   in_i,
  esd_stream_if.source out_o
);

  esd_pkg::stage_t  stage;
  esd_pkg::result_t result;
  logic             advance;
  logic             out_free;

  esd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  esd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .out_free_i (out_free),
    .advance_o  (advance),
    .result_o   (result)
  );

  esd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .result_i   (result),
    .out_o      (out_o),
    .out_free_o (out_free)
  );

endmodule

/* hw/rtl/esd_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the escape decoder.
module esd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] status_i,
  input logic       out_last_i
);

  // An error result always closes the string.
  `ASSERT_NEVER(a_err_last, clk_i, rst_ni, out_valid_i && (status_i != esd_pkg::ST_BYTE) && !out_last_i, "error result without out_last")

  // An error result carries a zero byte.
  `ASSERT_NEVER(a_err_zero, clk_i, rst_ni, out_valid_i && (status_i != esd_pkg::ST_BYTE) && (out_byte_i != esd_pkg::CH_NUL), "error result with non-zero byte")

  // A pending result is not withdrawn.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result withdrawn before it was taken")

  // A fresh result follows a byte accepted into the input register, since an empty result
  // register lets the input register pass its byte on at once.
  `ASSERT_CLK(a_out_source, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result without a preceding input request")

  // With the result register empty the decoder always takes a new byte.
  `ASSERT_CLK(a_in_ready, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input stalled while the output is empty")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.payload.out_byte),
  .status_i    (out_o.payload.status),
  .out_last_i  (out_o.payload.out_last)
);
